// File: rtl/dvc_pkg.sv
// ----------------------------------------------------------------------------
// dvc_pkg: shared types, codes and functions of the delta value cache.
// Request codes, the per-cell control bundle and the block size predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package dvc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE
  } dvc_state_t;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_PUSH   = 2'd2;

  localparam int SLOT_MAX       = 2;
  localparam int MIN_BLOCK_SIZE = 2;

  typedef struct packed {
    logic        apply;
    logic [31:0] key;
    logic [31:0] wr_data;
  } cell_ctl_t;

  // Highest bit transition inside the contiguous low mask, plus one, at least two.
  function automatic logic [5:0] predict_size(input logic [31:0] delta,
                                              input logic [31:0] mask);
    logic [31:0] in_mask;
    logic [4:0]  change;
    in_mask    = '0;
    in_mask[0] = 1'b1;
    change     = '0;
    for (int j = 1; j < 32; j++) begin
      in_mask[j] = in_mask[j-1] & mask[j];
    end
    for (int j = 1; j < 32; j++) begin
      if (in_mask[j] && (delta[j] != delta[j-1])) begin
        change = 5'(j);
      end
    end
    if (change == 5'd0) begin
      return 6'(MIN_BLOCK_SIZE);
    end
    return 6'(change) + 6'd1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dvc_req_if.sv
// ----------------------------------------------------------------------------
// dvc_req_if: request channel of the delta value cache.
// Valid/ready handshake carrying the request type, value and mask.
// ----------------------------------------------------------------------------
`default_nettype none

interface dvc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] data_value;
  logic [31:0] value_mask;

  modport source (output valid, req_type, data_value, value_mask, input ready);
  modport sink   (input valid, req_type, data_value, value_mask, output ready);
endinterface

`default_nettype wire

// File: rtl/dvc_rsp_if.sv
// ----------------------------------------------------------------------------
// dvc_rsp_if: response channel of the delta value cache.
// Valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface dvc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [3:0]  hit_index;
  logic [31:0] out_value;
  logic        same_diff;
  logic [5:0]  block_size;

  modport source (output valid, hit, hit_index, out_value, same_diff, block_size,
                  input ready);
  modport sink   (input valid, hit, hit_index, out_value, same_diff, block_size,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/dvc_cell.sv
// ----------------------------------------------------------------------------
// dvc_cell: one entry of the cache row.
// Holds a value, compares it with the search key and on an update either
// loads the new value, takes its front neighbor's value or keeps its own.
// ----------------------------------------------------------------------------
`default_nettype none

module dvc_cell #(
  parameter int CACHE_DEPTH = 16,
  parameter int CELL_IDX    = 0,
  localparam int IW = $clog2(CACHE_DEPTH),
  localparam int CW = $clog2(CACHE_DEPTH + 1)
) (
  input  wire                     clk,
  input  wire dvc_pkg::cell_ctl_t ctl,
  input  wire logic [IW-1:0]      lo,
  input  wire logic [IW-1:0]      hi,
  input  wire logic [CW-1:0]      count,
  input  wire logic [31:0]        prev_entry,
  output logic [31:0]             entry,
  output logic                    match
);
  import dvc_pkg::*;

  localparam logic [IW-1:0] MY_POS = IW'(CELL_IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(CELL_IDX);

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      if (MY_POS == lo) begin
        entry <= ctl.wr_data;
      end else if ((MY_POS > lo) && (MY_POS <= hi)) begin
        entry <= prev_entry;
      end
    end
  end

  assign match = (MY_CNT < count) && (entry == ctl.key);

endmodule

`default_nettype wire

// File: rtl/delta_value_cache_core.sv
// ----------------------------------------------------------------------------
// delta_value_cache_core: self-organizing value cache for a compressor.
// A row of cells, one per entry, searched in parallel and shifted in place.
// ----------------------------------------------------------------------------
// Each request passes through the idle (capture) state, a compare state in which every
// cell compares its entry with the key while the delta and the predicted block
// size are formed, and an update state in which the first match is encoded, the
// row shifts by one cell per entry and the result is registered. A new request
// is taken only in the idle state, so requests never overlap; a result that is
// not taken holds the update state. Entries hold no reset value; only the first
// count of them ever take part in a search.
`default_nettype none

module delta_value_cache_core #(
  parameter int CACHE_DEPTH = 16
) (
  input  wire       clk,
  input  wire       rst,
  dvc_req_if.sink   req,
  dvc_rsp_if.source rsp
);
  import dvc_pkg::*;

  localparam int IW = $clog2(CACHE_DEPTH);
  localparam int CW = $clog2(CACHE_DEPTH + 1);
  localparam logic [CACHE_DEPTH-1:0] ONE_VEC = CACHE_DEPTH'(1);

  dvc_state_t state, state_next;

  logic [1:0]  rq_type;
  logic [31:0] rq_value;
  logic [31:0] rq_mask;

  logic [CW-1:0] count;
  logic [31:0]   prev_delta;
  logic [31:0]   last_ins;
  logic [5:0]    pred;

  logic [CACHE_DEPTH-1:0] match, match_r;
  logic [31:0]            delta, delta_r;
  logic [5:0]             pred_r;

  logic [31:0] entry_chain [CACHE_DEPTH];
  cell_ctl_t   ctl;

  logic                   adv;
  logic [CACHE_DEPTH-1:0] first;
  logic [IW-1:0]          hit_pos;
  logic                   full;
  logic [IW-1:0]          hi_ins;
  logic [IW-1:0]          slot;
  logic [31:0]            ins_val;
  logic                   do_write;
  logic [IW-1:0]          lo, hi;
  logic [31:0]            wr_data;
  logic                   grow;
  logic                   set_last;
  logic [31:0]            new_last;
  logic                   ld_delta;
  logic                   res_hit;
  logic [3:0]             res_idx;
  logic [31:0]            res_val;
  logic                   res_same;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (req.valid) state_next = ST_COMPARE;
      ST_COMPARE: state_next = ST_UPDATE;
      ST_UPDATE:  if (adv) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    adv       = (state == ST_UPDATE) && (!rsp.valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      rq_type  <= req.req_type;
      rq_value <= req.data_value;
      rq_mask  <= req.value_mask;
    end
  end

  assign delta = (rq_type == REQ_INSERT) ? rq_value : ((rq_value - last_ins) & rq_mask);

  always_ff @(posedge clk) begin
    if (state == ST_COMPARE) begin
      match_r <= match;
      delta_r <= delta;
      pred_r  <= predict_size(delta, rq_mask);
    end
  end

  assign ctl.apply   = adv && do_write;
  assign ctl.key     = rq_value;
  assign ctl.wr_data = wr_data;

  for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
    logic [31:0] prev_in;
    if (i == 0) begin : g_head
      assign prev_in = '0;
    end else begin : g_body
      assign prev_in = entry_chain[i-1];
    end
    dvc_cell #(
      .CACHE_DEPTH (CACHE_DEPTH),
      .CELL_IDX    (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .lo         (lo),
      .hi         (hi),
      .count      (count),
      .prev_entry (prev_in),
      .entry      (entry_chain[i]),
      .match      (match[i])
    );
  end

  always_comb begin
    first   = match_r & (~match_r + ONE_VEC);
    hit_pos = '0;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (first[i]) begin
        hit_pos = hit_pos | IW'(i);
      end
    end
    full     = (count == CW'(CACHE_DEPTH));
    hi_ins   = full ? IW'(CACHE_DEPTH - 1) : IW'(count);
    slot     = (count <= CW'(SLOT_MAX)) ? IW'(count) : IW'(SLOT_MAX);
    ins_val  = (last_ins + rq_value) & rq_mask;
    do_write = 1'b0;
    lo       = '0;
    hi       = '0;
    wr_data  = rq_value;
    grow     = 1'b0;
    set_last = 1'b0;
    new_last = last_ins;
    ld_delta = 1'b0;
    res_hit  = 1'b0;
    res_idx  = '0;
    res_val  = '0;
    res_same = 1'b0;
    case (rq_type)
      REQ_LOOKUP: begin
        do_write = 1'b1;
        if (|match_r) begin
          lo      = hit_pos >> 1;
          hi      = hit_pos;
          res_hit = 1'b1;
          res_idx = 4'(hit_pos);
        end else begin
          lo       = slot;
          hi       = hi_ins;
          grow     = !full;
          set_last = 1'b1;
          new_last = rq_value & rq_mask;
          res_val  = delta_r;
          res_same = (delta_r == prev_delta);
          ld_delta = (delta_r != prev_delta);
        end
      end
      REQ_INSERT: begin
        do_write = 1'b1;
        lo       = slot;
        hi       = hi_ins;
        wr_data  = ins_val;
        grow     = !full;
        set_last = 1'b1;
        new_last = ins_val;
        res_val  = ins_val;
        ld_delta = (delta_r != prev_delta);
      end
      REQ_PUSH: begin
        do_write = 1'b1;
        lo       = '0;
        hi       = hi_ins;
        wr_data  = rq_value & rq_mask;
        grow     = !full;
        res_val  = rq_value & rq_mask;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      prev_delta <= '0;
      last_ins   <= '0;
      pred       <= '0;
    end else if (adv) begin
      if (grow) begin
        count <= count + CW'(1);
      end
      if (set_last) begin
        last_ins <= new_last;
      end
      if (ld_delta) begin
        prev_delta <= delta_r;
        pred       <= pred_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.hit        <= res_hit;
      rsp.hit_index  <= res_idx;
      rsp.out_value  <= res_val;
      rsp.same_diff  <= res_same;
      rsp.block_size <= ld_delta ? pred_r : pred;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dvc_checker.sv
// ----------------------------------------------------------------------------
// dvc_checker: port-level checks of the delta value cache.
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dvc_checker (
  input wire              clk,
  input wire              rst,
  input wire              req_valid,
  input wire              req_ready,
  input wire              rsp_valid,
  input wire              rsp_ready,
  input wire              rsp_hit,
  input wire logic [3:0]  rsp_hit_index,
  input wire logic [31:0] rsp_out_value,
  input wire              rsp_same_diff,
  input wire logic [5:0]  rsp_block_size
);

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is in progress");

  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped before it was taken");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_hit) && $stable(rsp_hit_index) &&
      $stable(rsp_out_value) && $stable(rsp_same_diff) && $stable(rsp_block_size))
    else $error("response changed while stalled");

  a_index_without_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_hit |-> rsp_hit_index == 4'd0)
    else $error("hit index set on a response without a hit");

  a_hit_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_hit |-> (rsp_out_value == 32'd0) && !rsp_same_diff)
    else $error("hit response carries a delta");

endmodule

bind delta_value_cache_core dvc_checker u_dvc_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_hit        (rsp.hit),
  .rsp_hit_index  (rsp.hit_index),
  .rsp_out_value  (rsp.out_value),
  .rsp_same_diff  (rsp.same_diff),
  .rsp_block_size (rsp.block_size)
);

`default_nettype wire

// File: tb/delta_value_cache_core_test.sv
// ----------------------------------------------------------------------------
// delta_value_cache_core_test: self-checking bench for the delta value cache.
// Lookups, delta inserts and front pushes are driven through the request
// channel with random gaps, and every response is compared with a
// cycle-free model of the self-organizing cache and its size predictor.
// The responder stalls at random, and once for a long stretch, so that the
// block backs up into its request channel.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_value_cache_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dvc_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic        hit;
    logic [3:0]  hit_index;
    logic [31:0] out_value;
    logic        same_diff;
    logic [5:0]  block_size;
  } cache_result_t;

  class value_cache_model;
    logic [31:0]   entries [DEPTH];
    int unsigned   count;
    logic [31:0]   prev_delta;
    logic [31:0]   last_ins;
    logic [5:0]    pred_size;
    cache_result_t expected_rsp [$];
    int unsigned   errors;

    function new();
      count      = 0;
      prev_delta = '0;
      last_ins   = '0;
      pred_size  = '0;
      errors     = 0;
    endfunction

    function logic [5:0] block_size_for(logic [31:0] delta, logic [31:0] mask);
      int unsigned change;
      logic        run;
      logic        scanning;
      change   = 0;
      run      = delta[0];
      scanning = 1'b1;
      for (int j = 1; j < 32; j++) begin
        if (!mask[j]) scanning = 1'b0;
        if (scanning && (delta[j] != run)) begin
          change = j;
          run    = delta[j];
        end
      end
      return (change + 1 < 2) ? 6'd2 : 6'(change + 1);
    endfunction

    function int unsigned open_slot(int unsigned slot_cap);
      int unsigned slot;
      int unsigned k;
      slot = (count <= slot_cap) ? count : slot_cap;
      if (count >= DEPTH) begin
        k = DEPTH - 1;
      end else begin
        k = count;
        count++;
      end
      for (; k > slot; k--) entries[k] = entries[k-1];
      return slot;
    endfunction

    function void note_request(logic [1:0] kind, logic [31:0] value, logic [31:0] mask);
      cache_result_t r;
      int unsigned   slot;
      int unsigned   target;
      logic [31:0]   delta;
      r = '{hit: 1'b0, hit_index: 4'd0, out_value: 32'd0, same_diff: 1'b0,
            block_size: 6'd0};
      case (kind)
        REQ_LOOKUP: begin
          for (int unsigned i = 0; i < count; i++) begin
            if (!r.hit && entries[i] == value) begin
              r.hit       = 1'b1;
              r.hit_index = 4'(i);
              target      = i >> 1;
              for (int unsigned k = i; k > target; k--) entries[k] = entries[k-1];
              entries[target] = value;
            end
          end
          if (!r.hit) begin
            slot          = open_slot(SLOT_MAX);
            entries[slot] = value;
            delta         = (value - last_ins) & mask;
            last_ins      = value & mask;
            r.out_value   = delta;
            r.same_diff   = (delta == prev_delta);
            if (!r.same_diff) begin
              prev_delta = delta;
              pred_size  = block_size_for(delta, mask);
            end
          end
        end
        REQ_INSERT: begin
          slot = open_slot(SLOT_MAX);
          if (prev_delta != value) begin
            prev_delta = value;
            pred_size  = block_size_for(value, mask);
          end
          last_ins      = (last_ins + value) & mask;
          entries[slot] = last_ins;
          r.out_value   = last_ins;
        end
        REQ_PUSH: begin
          slot        = open_slot(0);
          r.out_value = value & mask;
          entries[0]  = r.out_value;
        end
        default: begin
        end
      endcase
      r.block_size = pred_size;
      expected_rsp.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task check_response(cache_result_t got);
      cache_result_t want;
      if (expected_rsp.size() == 0) begin
        report("unexpected response", 32'(got.out_value), 32'd0);
      end else begin
        want = expected_rsp.pop_front();
        if (got.hit !== want.hit) report("hit", 32'(got.hit), 32'(want.hit));
        if (got.hit_index !== want.hit_index)
          report("hit_index", 32'(got.hit_index), 32'(want.hit_index));
        if (got.out_value !== want.out_value) report("out_value", got.out_value, want.out_value);
        if (got.same_diff !== want.same_diff)
          report("same_diff", 32'(got.same_diff), 32'(want.same_diff));
        if (got.block_size !== want.block_size)
          report("block_size", 32'(got.block_size), 32'(want.block_size));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  int unsigned requests_sent;
  int unsigned cycles;

  value_cache_model cache_model;
  logic [31:0]      value_pool [20];

  dvc_req_if req_ch ();
  dvc_rsp_if rsp_ch ();

  delta_value_cache_core #(.CACHE_DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [31:0] pick_mask();
    int unsigned r;
    int unsigned w;
    r = $urandom_range(0, 99);
    w = $urandom_range(0, 32);
    if (r < 30) return '1;
    if (r < 80) return (w == 32) ? '1 : ((32'd1 << w) - 32'd1);
    return $urandom();
  endfunction

  task send_request(logic [1:0] kind, logic [31:0] value, logic [31:0] mask);
    int unsigned n;
    n = gap_len();
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.data_value <= value;
    req_ch.value_mask <= mask;
    do @(posedge clk); while (!req_ch.ready);
    cache_model.note_request(kind, value, mask);
    requests_sent++;
  endtask

  task send_random_request();
    int unsigned r;
    int unsigned s;
    logic [1:0]  kind;
    logic [31:0] value;
    logic [31:0] mask;
    r    = $urandom_range(0, 99);
    s    = $urandom_range(0, 99);
    mask = pick_mask();
    if (r < 50) begin
      kind = REQ_LOOKUP;
      if (s < 35) begin
        value = value_pool[$urandom_range(0, 19)];
      end else if (s < 55 && cache_model.count > 0) begin
        value = cache_model.entries[$urandom_range(0, cache_model.count - 1)];
      end else if (s < 65) begin
        value = cache_model.last_ins + cache_model.prev_delta;
      end else begin
        value = $urandom();
      end
    end else if (r < 75) begin
      kind  = REQ_INSERT;
      value = (s < 25) ? cache_model.prev_delta : $urandom();
    end else begin
      kind  = REQ_PUSH;
      value = (s < 40) ? value_pool[$urandom_range(0, 19)] : $urandom();
    end
    send_request(kind, value, mask);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      cache_model.check_response('{hit: rsp_ch.hit, hit_index: rsp_ch.hit_index,
                                   out_value: rsp_ch.out_value,
                                   same_diff: rsp_ch.same_diff,
                                   block_size: rsp_ch.block_size});
    end
  end

  initial begin
    bit held;
    int unsigned n;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (!held && requests_sent >= HOLD_AFTER) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      n = gap_len();
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles", cycles);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    cache_model   = new();
    requests_sent = 0;
    for (int i = 0; i < 20; i++) value_pool[i] = $urandom();
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_LOOKUP;
    req_ch.data_value <= '0;
    req_ch.value_mask <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty cache, hit at the front, all-ones value and narrow mask.
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'h1234_5678, 32'h0000_00FF);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    // Equal successive deltas set the same-delta flag.
    send_request(REQ_LOOKUP, 32'd100, 32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'd200, 32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'd300, 32'hFFFF_FFFF);
    // Inserts with a repeated delta, the widest delta and a narrow mask.
    send_request(REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'h0000_0005, 32'h0000_000F);
    send_request(REQ_INSERT, 32'hAAAA_AAAA, 32'h7FFF_FFFF);
    send_request(REQ_PUSH, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_PUSH, 32'hABCD_EF01, 32'h0000_FFFF);
    // Fill the cache so that stores evict the last entry.
    for (int i = 0; i < 6; i++) send_request(REQ_PUSH, 32'hC0DE_0000 + i, 32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'hC0DE_0000, 32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'h5555_5555, 32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, cache_model.entries[DEPTH-1], 32'hFFFF_FFFF);

    for (int i = 0; i < RANDOM_ITEMS; i++) send_random_request();
    req_ch.valid <= 1'b0;

    while (cache_model.expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (cache_model.errors == 0 && cache_model.expected_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: delta_value_cache_core.f
rtl/dvc_pkg.sv
rtl/dvc_req_if.sv
rtl/dvc_rsp_if.sv
rtl/dvc_cell.sv
rtl/delta_value_cache_core.sv
rtl/dvc_checker.sv
tb/delta_value_cache_core_test.sv
